FILE: design/ngahr_pkg.sv
// Shared types and constants of the noise gate: field widths, fixed-point
// constants, register indexes, multiplier operand selects and the command bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ngahr_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS   = 16;
	localparam int HOLD_BITS   = 20;

	localparam int THR_BITS  = SAMPLE_BITS - 1;
	localparam int GAIN_BITS = COEF_BITS + 1;

	// shared multiplier operand widths (signed)
	localparam int MUL_A_BITS = (SAMPLE_BITS + 1 > COEF_BITS + 2) ? SAMPLE_BITS + 1
	                                                             : COEF_BITS + 2;
	localparam int MUL_B_BITS = COEF_BITS + 2;
	localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

	localparam longint unsigned ONE_Q     = 64'd1 << COEF_BITS;
	localparam longint unsigned SNAP_HIGH = (ONE_Q * 999 + 999) / 1000;
	localparam longint unsigned SNAP_LOW  = ONE_Q / 1000;

	// register map, index = byte address / 4
	localparam logic [2:0] REG_OPEN_THRESHOLD    = 3'd0;
	localparam logic [2:0] REG_ENV_ATTACK_COEFF  = 3'd1;
	localparam logic [2:0] REG_ENV_RELEASE_COEFF = 3'd2;
	localparam logic [2:0] REG_GAIN_RISE_COEFF   = 3'd3;
	localparam logic [2:0] REG_GAIN_FALL_COEFF   = 3'd4;
	localparam logic [2:0] REG_HOLD_LENGTH       = 3'd5;

	localparam logic [THR_BITS-1:0]  RST_OPEN_THRESHOLD    = THR_BITS'(8389);
	localparam logic [COEF_BITS-1:0] RST_ENV_ATTACK_COEFF  = COEF_BITS'(0);
	localparam logic [COEF_BITS-1:0] RST_ENV_RELEASE_COEFF = COEF_BITS'(65000);
	localparam logic [COEF_BITS-1:0] RST_GAIN_RISE_COEFF   = COEF_BITS'(60000);
	localparam logic [COEF_BITS-1:0] RST_GAIN_FALL_COEFF   = COEF_BITS'(65000);
	localparam logic [HOLD_BITS-1:0] RST_HOLD_LENGTH       = HOLD_BITS'(2400);

	// gate phases
	localparam logic [1:0] PH_CLOSED  = 2'd0;
	localparam logic [1:0] PH_ATTACK  = 2'd1;
	localparam logic [1:0] PH_HOLD    = 2'd2;
	localparam logic [1:0] PH_RELEASE = 2'd3;

	// multiplier operand selects
	localparam logic [1:0] MUL_ENV  = 2'd0;
	localparam logic [1:0] MUL_GAIN = 2'd1;
	localparam logic [1:0] MUL_OUT  = 2'd2;

	typedef struct packed {
		logic [THR_BITS-1:0]  open_threshold;
		logic [COEF_BITS-1:0] env_attack_coeff;
		logic [COEF_BITS-1:0] env_release_coeff;
		logic [COEF_BITS-1:0] gain_rise_coeff;
		logic [COEF_BITS-1:0] gain_fall_coeff;
		logic [HOLD_BITS-1:0] hold_length;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       env_upd;
		logic       gate_upd;
		logic       gain_upd;
		logic       out_wr;
	} cmd_t;

endpackage

`default_nettype wire

FILE: design/noise_gate_attack_hold_release.sv
// Top level of the noise gate: APB register file, sequencer and datapath.
// Depends on ngahr_pkg, ngahr_ctrl and ngahr_dp.
`timescale 1ns / 1ps
`default_nettype none

// Sequence: load, envelope multiply and update, gate update, gain multiply and
//   update, output multiply and write; the write waits while the output register
//   is full. One item at a time; the single shared multiplier serves all three.
// The output register lets the next item enter while a result waits to be taken.
// Reset (arst_n low, asynchronous): envelope, gain and hold count clear, gate
//   closed, registers return to their defaults, no result pending.
module noise_gate_attack_hold_release (
	input  wire                                       clk,
	input  wire                                       arst_n,
	// configuration port
	input  wire                                       psel,
	input  wire                                       penable,
	input  wire                                       pwrite,
	input  wire  [4:0]                                paddr,
	input  wire  [31:0]                               pwdata,
	output logic [31:0]                               prdata,
	output logic                                      pready,
	// sample input
	input  wire                                       in_valid,
	output logic                                      in_ready,
	input  wire signed [ngahr_pkg::SAMPLE_BITS-1:0]   sample_in,
	// gated output
	output logic                                      out_valid,
	input  wire                                       out_ready,
	output logic signed [ngahr_pkg::SAMPLE_BITS-1:0]  sample_out
);

	ngahr_pkg::cfg_t cfg_q;
	ngahr_pkg::cmd_t cmd;
	logic            wr_en;
	logic [2:0]      reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	// the write lands on the access phase
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_threshold    <= ngahr_pkg::RST_OPEN_THRESHOLD;
			cfg_q.env_attack_coeff  <= ngahr_pkg::RST_ENV_ATTACK_COEFF;
			cfg_q.env_release_coeff <= ngahr_pkg::RST_ENV_RELEASE_COEFF;
			cfg_q.gain_rise_coeff   <= ngahr_pkg::RST_GAIN_RISE_COEFF;
			cfg_q.gain_fall_coeff   <= ngahr_pkg::RST_GAIN_FALL_COEFF;
			cfg_q.hold_length       <= ngahr_pkg::RST_HOLD_LENGTH;
		end else if (wr_en) begin
			unique case (reg_idx)
				ngahr_pkg::REG_OPEN_THRESHOLD:
					cfg_q.open_threshold <= pwdata[ngahr_pkg::THR_BITS-1:0];
				ngahr_pkg::REG_ENV_ATTACK_COEFF:
					cfg_q.env_attack_coeff <= pwdata[ngahr_pkg::COEF_BITS-1:0];
				ngahr_pkg::REG_ENV_RELEASE_COEFF:
					cfg_q.env_release_coeff <= pwdata[ngahr_pkg::COEF_BITS-1:0];
				ngahr_pkg::REG_GAIN_RISE_COEFF:
					cfg_q.gain_rise_coeff <= pwdata[ngahr_pkg::COEF_BITS-1:0];
				ngahr_pkg::REG_GAIN_FALL_COEFF:
					cfg_q.gain_fall_coeff <= pwdata[ngahr_pkg::COEF_BITS-1:0];
				ngahr_pkg::REG_HOLD_LENGTH:
					cfg_q.hold_length <= pwdata[ngahr_pkg::HOLD_BITS-1:0];
				default: begin
					// unmapped address: drop the write
				end
			endcase
		end
	end

	// read back, zero-extended
	always_comb begin
		unique case (reg_idx)
			ngahr_pkg::REG_OPEN_THRESHOLD:    prdata = 32'(cfg_q.open_threshold);
			ngahr_pkg::REG_ENV_ATTACK_COEFF:  prdata = 32'(cfg_q.env_attack_coeff);
			ngahr_pkg::REG_ENV_RELEASE_COEFF: prdata = 32'(cfg_q.env_release_coeff);
			ngahr_pkg::REG_GAIN_RISE_COEFF:   prdata = 32'(cfg_q.gain_rise_coeff);
			ngahr_pkg::REG_GAIN_FALL_COEFF:   prdata = 32'(cfg_q.gain_fall_coeff);
			ngahr_pkg::REG_HOLD_LENGTH:       prdata = 32'(cfg_q.hold_length);
			default:                          prdata = 32'd0;
		endcase
	end

	// sequencer: one item at a time, stalls only when the output register is full
	ngahr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// envelope follower, gate phases, gain ramp and output scaling
	ngahr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg_q),
		.sample_in  (sample_in),
		.sample_out (sample_out)
	);

endmodule

`default_nettype wire

FILE: design/ngahr_ctrl.sv
// Sequencer of the noise gate: steps one item through the datapath passes
// and owns the input and output handshakes. Depends on ngahr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ngahr_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire               out_ready,
	output ngahr_pkg::cmd_t   cmd
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_ENV_MUL  = 3'd1;
	localparam logic [2:0] ST_ENV_UPD  = 3'd2;
	localparam logic [2:0] ST_GATE     = 3'd3;
	localparam logic [2:0] ST_GAIN_MUL = 3'd4;
	localparam logic [2:0] ST_GAIN_UPD = 3'd5;
	localparam logic [2:0] ST_OUT_MUL  = 3'd6;
	localparam logic [2:0] ST_OUT_WR   = 3'd7;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_ENV_MUL;
				end
			end
			ST_ENV_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ngahr_pkg::MUL_ENV;
				state_d     = ST_ENV_UPD;
			end
			ST_ENV_UPD: begin
				cmd.env_upd = 1'b1;
				state_d     = ST_GATE;
			end
			ST_GATE: begin
				cmd.gate_upd = 1'b1;
				state_d      = ST_GAIN_MUL;
			end
			ST_GAIN_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ngahr_pkg::MUL_GAIN;
				state_d     = ST_GAIN_UPD;
			end
			ST_GAIN_UPD: begin
				cmd.gain_upd = 1'b1;
				state_d      = ST_OUT_MUL;
			end
			ST_OUT_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ngahr_pkg::MUL_OUT;
				state_d     = ST_OUT_WR;
			end
			ST_OUT_WR: begin
				if (out_free) begin
					cmd.out_wr = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_wr)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: design/ngahr_dp.sv
// Datapath of the noise gate: envelope, gate phase, hold counter, gain and
// one shared signed multiplier. Driven by ngahr_ctrl commands; uses ngahr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ngahr_dp (
	input  wire                                          clk,
	input  wire                                          arst_n,
	input  ngahr_pkg::cmd_t                              cmd,
	input  ngahr_pkg::cfg_t                              cfg,
	input  wire signed [ngahr_pkg::SAMPLE_BITS-1:0]      sample_in,
	output logic signed [ngahr_pkg::SAMPLE_BITS-1:0]     sample_out
);

	localparam int SB = ngahr_pkg::SAMPLE_BITS;
	localparam int CB = ngahr_pkg::COEF_BITS;
	localparam int HB = ngahr_pkg::HOLD_BITS;
	localparam int GB = ngahr_pkg::GAIN_BITS;
	localparam int AB = ngahr_pkg::MUL_A_BITS;
	localparam int BB = ngahr_pkg::MUL_B_BITS;
	localparam int PB = ngahr_pkg::PROD_BITS;
	localparam int YB = PB + 1 - CB;

	localparam logic [GB-1:0] GAIN_ONE  = GB'(ngahr_pkg::ONE_Q);
	localparam logic [GB-1:0] GAIN_HIGH = GB'(ngahr_pkg::SNAP_HIGH);
	localparam logic [GB-1:0] GAIN_LOW  = GB'(ngahr_pkg::SNAP_LOW);
	localparam logic signed [PB:0] HALF_ACC = (PB+1)'(ngahr_pkg::ONE_Q >> 1);
	localparam logic signed [YB-1:0] Y_HI = YB'((64'd1 << (SB - 1)) - 64'd1);
	localparam logic signed [YB-1:0] Y_LO = -Y_HI - YB'(1);

	logic signed [SB-1:0] x_q;
	logic [SB-1:0]        mag_q;
	logic [SB-1:0]        env_q;
	logic [GB-1:0]        gain_q;
	logic [1:0]           phase_q;
	logic [HB-1:0]        hold_q;
	logic                 tgt_q;
	logic [CB-1:0]        coef_q;
	logic signed [PB-1:0] prod_q;
	logic signed [SB-1:0] out_q;

	logic [SB-1:0]        mag_in;
	logic signed [AB-1:0] mul_a;
	logic signed [BB-1:0] mul_b;
	logic signed [PB:0]   env_acc;
	logic signed [PB:0]   gain_acc;
	logic signed [PB:0]   y_acc;
	logic signed [YB-1:0] y_full;
	logic signed [SB-1:0] y_sat;
	logic                 above;
	logic [1:0]           phase_n;
	logic [GB-1:0]        gain_n;
	logic [HB-1:0]        hold_n;
	logic                 tgt_n;

	assign mag_in = sample_in[SB-1] ? (~sample_in + SB'(1)) : sample_in;

	// shared multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			ngahr_pkg::MUL_ENV: begin
				mul_a = AB'($signed({1'b0, env_q}) - $signed({1'b0, mag_q}));
				mul_b = $signed({2'b00, coef_q});
			end
			ngahr_pkg::MUL_GAIN: begin
				mul_a = AB'($signed({1'b0, gain_q}) - $signed({1'b0, tgt_q, {CB{1'b0}}}));
				mul_b = $signed({2'b00, coef_q});
			end
			default: begin
				mul_a = AB'(x_q);
				mul_b = $signed({1'b0, gain_q});
			end
		endcase
	end

	// pole step: target*ONE + (old - target)*c + ONE/2, then drop CB bits
	assign env_acc = $signed({{(PB + 1 - SB - CB){1'b0}}, mag_q, {CB{1'b0}}})
	               + (PB+1)'(prod_q) + HALF_ACC;
	assign gain_acc = $signed({{(PB - 2 * CB){1'b0}}, tgt_q, {(2 * CB){1'b0}}})
	                + (PB+1)'(prod_q) + HALF_ACC;

	// output rounding (floor of p + half) and saturation
	assign y_acc  = (PB+1)'(prod_q) + HALF_ACC;
	assign y_full = y_acc[PB:CB];
	always_comb begin
		if (y_full > Y_HI)
			y_sat = SB'(Y_HI);
		else if (y_full < Y_LO)
			y_sat = SB'(Y_LO);
		else
			y_sat = SB'(y_full);
	end

	// gate phase update
	assign above = env_q >= {1'b0, cfg.open_threshold};

	always_comb begin
		phase_n = phase_q;
		gain_n  = gain_q;
		hold_n  = hold_q;
		case (phase_q)
			ngahr_pkg::PH_CLOSED: begin
				if (above)
					phase_n = ngahr_pkg::PH_ATTACK;
			end
			ngahr_pkg::PH_ATTACK: begin
				if (gain_q >= GAIN_HIGH) begin
					gain_n  = GAIN_ONE;
					hold_n  = cfg.hold_length;
					phase_n = ngahr_pkg::PH_HOLD;
				end
				if (!above)
					phase_n = ngahr_pkg::PH_RELEASE;
			end
			ngahr_pkg::PH_HOLD: begin
				if (hold_q <= HB'(1)) begin
					if (above)
						hold_n = cfg.hold_length;
					else begin
						hold_n  = '0;
						phase_n = ngahr_pkg::PH_RELEASE;
					end
				end else begin
					hold_n = hold_q - HB'(1);
				end
			end
			default: begin
				if (above)
					phase_n = ngahr_pkg::PH_ATTACK;
				else if (gain_q <= GAIN_LOW) begin
					gain_n  = '0;
					phase_n = ngahr_pkg::PH_CLOSED;
				end
			end
		endcase
		tgt_n = (phase_n == ngahr_pkg::PH_ATTACK) || (phase_n == ngahr_pkg::PH_HOLD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q   <= '0;
			gain_q  <= '0;
			phase_q <= ngahr_pkg::PH_CLOSED;
			hold_q  <= '0;
		end else begin
			if (cmd.env_upd)
				env_q <= env_acc[CB +: SB];
			if (cmd.gate_upd) begin
				phase_q <= phase_n;
				gain_q  <= gain_n;
				hold_q  <= hold_n;
			end else if (cmd.gain_upd) begin
				gain_q <= gain_acc[CB +: GB];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= sample_in;
			mag_q  <= mag_in;
			coef_q <= (mag_in > env_q) ? cfg.env_attack_coeff : cfg.env_release_coeff;
		end else if (cmd.gate_upd) begin
			tgt_q  <= tgt_n;
			coef_q <= (tgt_n && (gain_n < GAIN_ONE)) ? cfg.gain_rise_coeff
			                                         : cfg.gain_fall_coeff;
		end
		if (cmd.mul_en)
			prod_q <= mul_a * mul_b;
		if (cmd.out_wr)
			out_q <= y_sat;
	end

	assign sample_out = out_q;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for noise_gate_attack_hold_release: register writes over the APB port,
// a gated sample stream with paced bursts, and a local gate model checking each result.
// Depends on ngahr_pkg and the noise_gate_attack_hold_release RTL.
module tb_top;
	import ngahr_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 9;
	// the block takes one item at a time; leave margin before touching registers
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_OFF      = 300;
	localparam int STALL_LIMIT   = 3000;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 128;
	localparam int REPORT_MAX    = 10;
	// index just past the register list, written to prove it is ignored
	localparam logic [2:0] REG_SPARE = 3'd6;
	localparam longint SMP_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint SMP_MIN = -SMP_MAX - 1;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] pred;
		bit                            typed;
		logic signed [SAMPLE_BITS-1:0] want;
	} gated_t;

	typedef struct {
		bit                            is_cfg;
		logic [2:0]                    idx;
		logic [31:0]                   val;
		logic signed [SAMPLE_BITS-1:0] smp;
		bit                            typed;
		logic signed [SAMPLE_BITS-1:0] want;
	} step_t;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [4:0]                    paddr;
	logic [31:0]                   pwdata;
	wire  [31:0]                   prdata;
	wire                           pready;
	logic                          in_valid;
	wire                           in_ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	wire                           out_valid;
	logic                          out_ready;
	wire  signed [SAMPLE_BITS-1:0] sample_out;

	// typed expectation riding along with the sample on the input side
	logic                          tag_typed;
	logic signed [SAMPLE_BITS-1:0] tag_want;

	// gate model: register copy and state at the block's widths
	cfg_t                   gate_cfg;
	logic [SAMPLE_BITS-1:0] env_level;
	logic [1:0]             gate_ph;
	logic [GAIN_BITS-1:0]   gain_q;
	logic [HOLD_BITS-1:0]   hold_left;

	gated_t gated_q[$];
	gated_t landed;
	step_t  plan[$];

	int pending      = 0;
	int n_samples    = 0;
	int n_checked    = 0;
	int n_errors     = 0;
	int n_writes     = 0;
	int quiet_cycles = 0;
	int burst_left   = 0;
	int items_left   = 0;
	bit gaps_on      = 1'b1;
	bit hold_off_req = 1'b0;

	noise_gate_attack_hold_release u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_out(sample_out)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// One-pole step in Q0.16: blend the old value toward the aim, round half up.
	function automatic longint unsigned one_pole(longint unsigned aim, longint unsigned old,
			longint unsigned c);
		return (aim * (ONE_Q - c) + old * c + (ONE_Q >> 1)) >> COEF_BITS;
	endfunction

	// Advance the gate model by one sample and return the gated sample.
	function automatic logic signed [SAMPLE_BITS-1:0] gate_sample(
			logic signed [SAMPLE_BITS-1:0] s);
		longint          x;
		longint          mag;
		longint          y;
		longint unsigned aim;
		longint unsigned c;
		bit              above;
		x   = longint'(s);
		mag = (x < 0) ? -x : x;
		// envelope: attack pole on a rising level, release pole otherwise
		c = (mag > longint'(env_level)) ? gate_cfg.env_attack_coeff
		                                : gate_cfg.env_release_coeff;
		env_level = SAMPLE_BITS'(one_pole(mag, env_level, c));
		above = env_level >= gate_cfg.open_threshold;
		case (gate_ph)
			PH_CLOSED: begin
				if (above)
					gate_ph = PH_ATTACK;
			end
			PH_ATTACK: begin
				// snap to full gain near one, then the level decides hold or release
				if (gain_q >= SNAP_HIGH) begin
					gain_q    = GAIN_BITS'(ONE_Q);
					hold_left = gate_cfg.hold_length;
					gate_ph   = PH_HOLD;
				end
				if (!above)
					gate_ph = PH_RELEASE;
			end
			PH_HOLD: begin
				if (hold_left <= 1) begin
					hold_left = '0;
					if (above)
						hold_left = gate_cfg.hold_length;
					else
						gate_ph = PH_RELEASE;
				end else begin
					hold_left = hold_left - 1'b1;
				end
			end
			default: begin
				if (above) begin
					gate_ph = PH_ATTACK;
				end else if (gain_q <= SNAP_LOW) begin
					gain_q  = '0;
					gate_ph = PH_CLOSED;
				end
			end
		endcase
		aim = (gate_ph == PH_CLOSED || gate_ph == PH_RELEASE) ? 0 : ONE_Q;
		c   = (aim > gain_q) ? gate_cfg.gain_rise_coeff : gate_cfg.gain_fall_coeff;
		gain_q = GAIN_BITS'(one_pole(aim, gain_q, c));
		// scale, round half up, saturate
		y = (x * longint'(gain_q) + longint'(ONE_Q >> 1)) >>> COEF_BITS;
		if (y > SMP_MAX)
			y = SMP_MAX;
		if (y < SMP_MIN)
			y = SMP_MIN;
		return SAMPLE_BITS'(y);
	endfunction

	function automatic void mirror_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			REG_OPEN_THRESHOLD:    gate_cfg.open_threshold    = val[THR_BITS-1:0];
			REG_ENV_ATTACK_COEFF:  gate_cfg.env_attack_coeff  = val[COEF_BITS-1:0];
			REG_ENV_RELEASE_COEFF: gate_cfg.env_release_coeff = val[COEF_BITS-1:0];
			REG_GAIN_RISE_COEFF:   gate_cfg.gain_rise_coeff   = val[COEF_BITS-1:0];
			REG_GAIN_FALL_COEFF:   gate_cfg.gain_fall_coeff   = val[COEF_BITS-1:0];
			REG_HOLD_LENGTH:       gate_cfg.hold_length       = val[HOLD_BITS-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] reg_view(logic [2:0] idx);
		case (idx)
			REG_OPEN_THRESHOLD:    return 32'(gate_cfg.open_threshold);
			REG_ENV_ATTACK_COEFF:  return 32'(gate_cfg.env_attack_coeff);
			REG_ENV_RELEASE_COEFF: return 32'(gate_cfg.env_release_coeff);
			REG_GAIN_RISE_COEFF:   return 32'(gate_cfg.gain_rise_coeff);
			REG_GAIN_FALL_COEFF:   return 32'(gate_cfg.gain_fall_coeff);
			REG_HOLD_LENGTH:       return 32'(gate_cfg.hold_length);
			default:               return '0;
		endcase
	endfunction

	task automatic log_mismatch(string msg);
		n_errors++;
		if (n_errors <= REPORT_MAX)
			$display("%s", msg);
	endtask

	// One APB transfer: setup cycle, access cycle, then drop the select.
	task automatic apb_xfer(input bit wr, input logic [2:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write a register, track it in the model and read it back.
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		logic [31:0] back;
		apb_xfer(1'b1, idx, val, back);
		mirror_reg(idx, val);
		n_writes++;
		if (idx != REG_SPARE) begin
			apb_xfer(1'b0, idx, '0, back);
			if (back !== reg_view(idx))
				log_mismatch($sformatf("tb_top: register %0d reads %0h, expected %0h",
					idx, back, reg_view(idx)));
		end
	endtask

	task automatic write_setting(cfg_t s);
		write_reg(REG_OPEN_THRESHOLD, 32'(s.open_threshold));
		write_reg(REG_ENV_ATTACK_COEFF, 32'(s.env_attack_coeff));
		write_reg(REG_ENV_RELEASE_COEFF, 32'(s.env_release_coeff));
		write_reg(REG_GAIN_RISE_COEFF, 32'(s.gain_rise_coeff));
		write_reg(REG_GAIN_FALL_COEFF, 32'(s.gain_fall_coeff));
		write_reg(REG_HOLD_LENGTH, 32'(s.hold_length));
	endtask

	// Stop offering items, drain every result, then let the pipeline settle.
	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Offer one sample and hold it until the block takes it.
	task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s, bit typed,
			logic signed [SAMPLE_BITS-1:0] want);
		@(negedge clk);
		in_valid  <= 1'b1;
		sample_in <= s;
		tag_typed <= typed;
		tag_want  <= want;
		do @(posedge clk); while (!in_ready);
	endtask

	// Send in bursts, with a random gap between bursts when gaps are on.
	task automatic send_paced(logic signed [SAMPLE_BITS-1:0] s);
		int gap;
		if (burst_left == 0) begin
			if (gaps_on) begin
				gap = $urandom_range(1, 12);
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		send_sample(s, 1'b0, '0);
		items_left--;
	endtask

	// Loud samples sit well over the threshold, quiet ones well under it.
	function automatic logic signed [SAMPLE_BITS-1:0] shaped(bit loud);
		longint thr;
		longint lo;
		longint hi;
		longint mag;
		thr = longint'(gate_cfg.open_threshold);
		if (loud) begin
			lo = thr + thr / 2;
			if (lo > SMP_MAX)
				lo = SMP_MAX;
			hi = SMP_MAX;
		end else begin
			lo = 0;
			hi = thr / 4;
		end
		mag = lo + longint'($urandom_range(0, int'(hi - lo)));
		return SAMPLE_BITS'($urandom_range(0, 1) ? -mag : mag);
	endfunction

	task automatic segment(bit loud, int len);
		while (len > 0 && items_left > 0) begin
			send_paced(shaped(loud));
			len--;
		end
	endtask

	// Mostly open/close cycles with random content; some noise and cut-off blips.
	task automatic drive_phase(int count);
		items_left = count;
		while (items_left > 0) begin
			case ($urandom_range(0, 9))
				0: send_paced(SAMPLE_BITS'($urandom()));
				1: segment(1'b1, $urandom_range(1, 3));
				default: begin
					segment(1'b1, $urandom_range(5, 40));
					segment(1'b0, $urandom_range(5, 60));
				end
			endcase
		end
	endtask

	// Setting for a random phase; the first two are the extremes.
	function automatic cfg_t random_setting(int k);
		cfg_t s;
		if (k == 0) begin
			s.open_threshold    = THR_BITS'(1);
			s.env_attack_coeff  = '1;
			s.env_release_coeff = '1;
			s.gain_rise_coeff   = '1;
			s.gain_fall_coeff   = '1;
			s.hold_length       = '1;
		end else if (k == 1) begin
			s.open_threshold    = '1;
			s.env_attack_coeff  = '0;
			s.env_release_coeff = '0;
			s.gain_rise_coeff   = '0;
			s.gain_fall_coeff   = '0;
			s.hold_length       = '0;
		end else begin
			s.open_threshold = ($urandom_range(0, 3) == 0) ? THR_BITS'($urandom())
			                                               : THR_BITS'($urandom_range(0, 1 << 20));
			s.env_attack_coeff  = COEF_BITS'($urandom());
			s.env_release_coeff = COEF_BITS'($urandom());
			// keep the gain ramps short most of the time so the gate cycles often
			s.gain_rise_coeff = $urandom_range(0, 1) ? COEF_BITS'($urandom())
			                                         : COEF_BITS'($urandom_range(0, 40000));
			s.gain_fall_coeff = $urandom_range(0, 1) ? COEF_BITS'($urandom())
			                                         : COEF_BITS'($urandom_range(0, 40000));
			s.hold_length = ($urandom_range(0, 3) == 0) ? HOLD_BITS'($urandom())
			                                            : HOLD_BITS'($urandom_range(0, 40));
		end
		return s;
	endfunction

	function automatic void add_reg(logic [2:0] idx, logic [31:0] val);
		step_t st;
		st.is_cfg = 1'b1;
		st.idx    = idx;
		st.val    = val;
		st.smp    = '0;
		st.typed  = 1'b0;
		st.want   = '0;
		plan.push_back(st);
	endfunction

	function automatic void add_smp(longint s, bit typed, longint want);
		step_t st;
		st.is_cfg = 1'b0;
		st.idx    = '0;
		st.val    = '0;
		st.smp    = SAMPLE_BITS'(s);
		st.typed  = typed;
		st.want   = SAMPLE_BITS'(want);
		plan.push_back(st);
	endfunction

	// Receiver: cycle through stall patterns; honor a long hold-off on request.
	initial begin
		int tick;
		out_ready = 1'b0;
		tick = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_off_req) begin
				// drop ready and let the block back up into its input
				out_ready <= 1'b0;
				repeat (HOLD_OFF) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				case ((tick / 200) % 4)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					2: out_ready <= (tick % 4 != 0);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Monitor: check results against the oldest prediction, predict on each accept,
	// and watch for a stalled handshake.
	always @(posedge clk) begin
		if (arst_n) begin
			// check the output first so a result never pairs with a same-edge item
			if (out_valid && out_ready) begin
				if (gated_q.size() == 0) begin
					log_mismatch($sformatf("tb_top: result %0d with nothing expected",
						sample_out));
				end else begin
					landed = gated_q.pop_front();
					pending--;
					n_checked++;
					if (sample_out !== landed.pred)
						log_mismatch($sformatf("tb_top: result %0d: expected %0d, got %0d",
							n_checked, landed.pred, sample_out));
					else if (landed.typed && sample_out !== landed.want)
						log_mismatch($sformatf("tb_top: result %0d: table says %0d, got %0d",
							n_checked, landed.want, sample_out));
				end
			end
			if (in_valid && in_ready) begin
				landed.pred  = gate_sample(sample_in);
				landed.typed = tag_typed;
				landed.want  = tag_want;
				gated_q.push_back(landed);
				pending++;
				n_samples++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_top: no item moved for %0d cycles", STALL_LIMIT);
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	initial begin
		cfg_t setting;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		sample_in = '0;
		tag_typed = 1'b0;
		tag_want  = '0;

		// model starts from the reset defaults
		gate_cfg.open_threshold    = RST_OPEN_THRESHOLD;
		gate_cfg.env_attack_coeff  = RST_ENV_ATTACK_COEFF;
		gate_cfg.env_release_coeff = RST_ENV_RELEASE_COEFF;
		gate_cfg.gain_rise_coeff   = RST_GAIN_RISE_COEFF;
		gate_cfg.gain_fall_coeff   = RST_GAIN_FALL_COEFF;
		gate_cfg.hold_length       = RST_HOLD_LENGTH;
		env_level = '0;
		gate_ph   = PH_CLOSED;
		gain_q    = '0;
		hold_left = '0;

		// Directed table. Reset defaults: a closed gate outputs zero.
		add_smp(0, 1'b1, 0);
		add_smp(100, 1'b1, 0);
		add_smp(SMP_MIN, 1'b0, 0);
		add_smp(SMP_MAX, 1'b0, 0);
		add_smp(-1, 1'b0, 0);
		// Instant poles and a zero threshold: the gate is fully open, samples pass.
		add_reg(REG_OPEN_THRESHOLD, 32'd0);
		add_reg(REG_ENV_ATTACK_COEFF, 32'd0);
		add_reg(REG_ENV_RELEASE_COEFF, 32'd0);
		add_reg(REG_GAIN_RISE_COEFF, 32'd0);
		add_reg(REG_GAIN_FALL_COEFF, 32'd0);
		add_reg(REG_HOLD_LENGTH, 32'd0);
		add_reg(REG_SPARE, 32'hFFFF_FFFF);
		add_smp(SMP_MAX, 1'b1, SMP_MAX);
		add_smp(SMP_MIN, 1'b1, SMP_MIN);
		add_smp(-1, 1'b1, -1);
		add_smp(1, 1'b1, 1);
		add_smp(0, 1'b1, 0);
		// Top threshold: hold expires into release, near-zero snap closes,
		// full scale (most negative too) reopens, near-one snap with a low level.
		add_reg(REG_OPEN_THRESHOLD, 32'(SMP_MAX));
		add_smp(5, 1'b1, 0);
		add_smp(7, 1'b1, 0);
		add_smp(SMP_MIN, 1'b1, SMP_MIN);
		add_smp(3, 1'b1, 0);
		add_smp(SMP_MAX, 1'b1, SMP_MAX);
		add_smp(SMP_MAX, 1'b1, SMP_MAX);
		add_smp(-SMP_MAX, 1'b1, -SMP_MAX);
		// Short hold: reload at full level, count down, expire into release.
		add_reg(REG_HOLD_LENGTH, 32'd3);
		add_smp(SMP_MAX, 1'b1, SMP_MAX);
		add_smp(10, 1'b1, 10);
		add_smp(10, 1'b1, 10);
		add_smp(10, 1'b1, 0);
		// Slow gain ramps, mid threshold: predicted only.
		add_reg(REG_OPEN_THRESHOLD, 32'd1000);
		add_reg(REG_GAIN_RISE_COEFF, 32'd60000);
		add_reg(REG_GAIN_FALL_COEFF, 32'd65000);
		add_smp(5000, 1'b0, 0);
		add_smp(-5000, 1'b0, 0);
		add_smp(20, 1'b0, 0);
		add_smp(0, 1'b0, 0);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				quiesce();
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				send_sample(plan[i].smp, plan[i].typed, plan[i].want);
			end
		end

		// Random phases, each under a fresh register setting.
		for (int k = 0; k < PHASES; k++) begin
			quiesce();
			setting = random_setting(k);
			write_setting(setting);
			gaps_on = (k % 2 == 0);
			burst_left = 0;
			// back-pressure run: receiver holds off while the sender keeps going
			if (k == 3)
				hold_off_req = 1'b1;
			drive_phase(PHASE_ITEMS);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("tb_top: %0d samples sent, %0d gated results compared, %0d mismatches",
			n_samples, n_checked, n_errors);
		$display("tb_top: %0d register writes, directed table plus %0d random settings",
			n_writes, PHASES);
		if (n_errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
